FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, switched off while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check on clk that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cap_pkg.sv
// shared types and constants of the class argmax persistence filter
`timescale 1ns / 1ps

package cap_pkg;

  localparam int SCORE_W = 8;
  localparam int CLASS_W = 6;
  localparam int COUNT_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_REPEATS   = 1'b1;

  localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 8'd200;
  localparam logic [COUNT_W-1:0] REPEATS_RESET   = 8'd3;

  typedef struct packed {
    logic [SCORE_W-1:0] threshold;
    logic [COUNT_W-1:0] repeats;
  } cfg_t;

  // argmax of one finished frame
  typedef struct packed {
    logic [SCORE_W-1:0] best;
    logic [CLASS_W-1:0] cls;
  } frame_sum_t;

  typedef struct packed {
    logic               show;
    logic               detected;
    logic [CLASS_W-1:0] sign_class;
    logic [SCORE_W-1:0] best_score;
  } result_t;

endpackage

FILE: rtl/cap_argmax.sv
// running argmax over the scores of one frame
`timescale 1ns / 1ps

module cap_argmax #(
  parameter int MAX_CLASSES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cap_pkg::SCORE_W-1:0] score,
  input  logic                      frame_end,
  output logic                      sum_valid,
  input  logic                      sum_ready,
  output cap_pkg::frame_sum_t       sum
);
  import cap_pkg::*;

  localparam int IDX_W = $clog2(MAX_CLASSES);
  localparam int POS_W = $clog2(MAX_CLASSES + 1);
  localparam int EXT_W = (IDX_W > CLASS_W) ? IDX_W : CLASS_W;

  logic [SCORE_W-1:0] running_max;
  logic [IDX_W-1:0]   running_index;
  logic [POS_W-1:0]   position;

  logic               in_take;
  logic               in_room;
  logic               hit;
  logic [SCORE_W-1:0] running_max_next;
  logic [IDX_W-1:0]   running_index_next;
  logic [POS_W-1:0]   position_next;
  logic [EXT_W-1:0]   index_ext;

  assign in_ready = !sum_valid || sum_ready;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_room            = position < POS_W'(MAX_CLASSES);
    // strict compare keeps the lowest index on a tie
    hit                = in_room && (score > running_max);
    running_max_next   = hit ? score : running_max;
    running_index_next = hit ? position[IDX_W-1:0] : running_index;
    position_next      = in_room ? position + 1'b1 : position;
    index_ext          = EXT_W'(running_index_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max   <= '0;
      running_index <= '0;
      position      <= '0;
      sum_valid     <= 1'b0;
    end else begin
      if (in_take) begin
        if (frame_end) begin
          running_max   <= '0;
          running_index <= '0;
          position      <= '0;
          sum.best      <= running_max_next;
          sum.cls       <= index_ext[CLASS_W-1:0];
        end else begin
          running_max   <= running_max_next;
          running_index <= running_index_next;
          position      <= position_next;
        end
      end
      if (in_take && frame_end) begin
        sum_valid <= 1'b1;
      end else if (sum_ready) begin
        sum_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/cap_persist.sv
// threshold decision, repeat filter and result register
`timescale 1ns / 1ps

module cap_persist (
  input  logic                clk,
  input  logic                rst,
  input  cap_pkg::cfg_t       cfg,
  input  logic                sum_valid,
  output logic                sum_ready,
  input  cap_pkg::frame_sum_t sum,
  output logic                out_valid,
  input  logic                out_ready,
  output cap_pkg::result_t    res
);
  import cap_pkg::*;

  typedef enum logic [1:0] {
    KIND_UNSEEN  = 2'd0,
    KIND_NOTHING = 2'd1,
    KIND_CLASS   = 2'd2
  } kind_t;

  kind_t              prior_kind;
  logic [CLASS_W-1:0] prior_class;
  logic [COUNT_W-1:0] run_count;

  logic               take;
  logic               det;
  kind_t              kind;
  logic [CLASS_W-1:0] cls;
  logic               same;
  logic [COUNT_W-1:0] run_count_next;
  logic               show;

  assign sum_ready = !out_valid || out_ready;
  assign take      = sum_valid && sum_ready;

  always_comb begin
    det  = sum.best > cfg.threshold;
    if (det) begin
      kind = KIND_CLASS;
    end else begin
      kind = KIND_NOTHING;
    end
    cls  = det ? sum.cls : '0;
    same = (prior_kind == kind) && ((kind != KIND_CLASS) || (prior_class == cls));
    if (!same) begin
      run_count_next = COUNT_W'(1);
    end else if (run_count == COUNT_MAX) begin
      run_count_next = run_count;
    end else begin
      run_count_next = run_count + 1'b1;
    end
    show = run_count_next >= cfg.repeats;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_kind  <= KIND_UNSEEN;
      prior_class <= '0;
      run_count   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        out_valid      <= 1'b1;
        prior_kind     <= kind;
        run_count      <= run_count_next;
        if (det) begin
          prior_class <= cls;
        end
        res.show       <= show;
        res.detected   <= det;
        res.sign_class <= cls;
        res.best_score <= sum.best;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/class_argmax_persistence_filter.sv
// argmax over per-class scores with strict threshold and repeat debounce
// throughput: one score beat per cycle while in_ready is high, set by the compare and update of the argmax
// out_valid rises after the accepted frame_end beat has passed the summary register and then the result register
// a stalled output holds one result plus one frame summary before in_ready drops
// rst is synchronous: clears argmax, decision history and valid flags, loads 200 and 3
`timescale 1ns / 1ps

module class_argmax_persistence_filter #(
  parameter int MAX_CLASSES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [cap_pkg::SCORE_W-1:0] cfg_data,
  // score beats
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cap_pkg::SCORE_W-1:0] score,
  input  logic                        frame_end,
  // one result beat per frame
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        show,
  output logic                        detected,
  output logic [cap_pkg::CLASS_W-1:0] sign_class,
  output logic [cap_pkg::SCORE_W-1:0] best_score
);
  import cap_pkg::*;

  cfg_t       cfg;
  logic       sum_valid;
  logic       sum_ready;
  frame_sum_t sum;
  result_t    res;

  // configuration registers; write them only while no frame is in flight (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RESET;
      cfg.repeats   <= REPEATS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_THRESHOLD: cfg.threshold <= cfg_data;
        CFG_REPEATS:   cfg.repeats   <= cfg_data;
      endcase
    end
  end

  // first stage: running max, first index wins a tie, summary latched on frame_end
  cap_argmax #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_argmax (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .score    (score),
    .frame_end(frame_end),
    .sum_valid(sum_valid),
    .sum_ready(sum_ready),
    .sum      (sum)
  );

  // second stage: threshold, repeat count and the result register
  cap_persist u_persist (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .sum_valid(sum_valid),
    .sum_ready(sum_ready),
    .sum      (sum),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res)
  );

  assign show       = res.show;
  assign detected   = res.detected;
  assign sign_class = res.sign_class;
  assign best_score = res.best_score;

endmodule

FILE: rtl/cap_checker.sv
// port-level checks of the class argmax persistence filter, bound to the top level
`include "assert_macros.svh"
`timescale 1ns / 1ps

module cap_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        frame_end,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        show,
  input logic                        detected,
  input logic [cap_pkg::CLASS_W-1:0] sign_class,
  input logic [cap_pkg::SCORE_W-1:0] best_score
);

  // a stalled result beat keeps its payload
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(show) && $stable(detected) && $stable(sign_class) && $stable(best_score), "result beat changed while stalled")

  // reset empties the result register
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // a fresh result comes from an accepted frame_end beat, through the summary register
  `ASSERT_CLK(a_result_source, $rose(out_valid) |-> $past(in_valid && in_ready && frame_end, 2), "result without a frame end beat")

  // input only stalls when both result and summary are held
  `ASSERT_CLK(a_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled with free output")

  // no class reported without a detection
  `ASSERT_CLK(a_class_zero, out_valid && !detected |-> sign_class == '0, "class index set without detection")

endmodule

bind class_argmax_persistence_filter cap_checker u_cap_checker (.*);
